@@ rtl/core/ali_pkg.sv @@
// Shared types and codes for the activity LED indicator.
package ali_pkg;

    // Event codes carried in the func field; codes 6 and 7 are unused.
    typedef enum logic [2:0] {
        FUNC_TICK      = 3'd0,
        FUNC_CAMERA    = 3'd1,
        FUNC_REQ_BEGIN = 3'd2,
        FUNC_REQ_END   = 3'd3,
        FUNC_RESET     = 3'd4,
        FUNC_ENABLE    = 3'd5
    } func_t;

    // LED colour codes.
    typedef enum logic [2:0] {
        COL_OFF    = 3'd0,
        COL_WHITE  = 3'd1,
        COL_RED    = 3'd2,
        COL_BLUE   = 3'd3,
        COL_YELLOW = 3'd4,
        COL_GREEN  = 3'd5
    } color_t;

    // Configuration register indexes (word address).
    typedef enum logic [1:0] {
        REG_PULSE_MS   = 2'd0,
        REG_REFRESH_MS = 2'd1,
        REG_RATE_LIMIT = 2'd2
    } reg_idx_t;

    localparam logic [15:0] PULSE_MS_RST   = 16'd180;
    localparam logic [15:0] REFRESH_MS_RST = 16'd1000;
    localparam logic [9:0]  RATE_LIMIT_RST = 10'd429;
    localparam logic [9:0]  HTTP_OK        = 10'd200;
    localparam logic [7:0]  OPEN_MAX       = 8'd255;

endpackage

@@ rtl/core/activity_led_indicator.sv @@
// Activity LED indicator: event-driven colour control for two status LEDs.
//
// Usage:
//  - Input channel (s_valid/s_ready): one event request per item. func selects
//    tick, camera result, request begin/end, reset or enable; now_ms is the
//    millisecond clock. On a tick the block decides whether each LED is
//    rewritten; left_bus_ok/right_bus_ok tell it whether that write would land.
//  - Result channel (m_valid/m_ready): exactly one result request per event,
//    carrying the LED write flags, colours, release_all and requests_open.
//  - APB port: pulse_ms at 0x0, refresh_interval_ms at 0x4, rate_limit_status
//    at 0x8. Write only while the block is idle. pready is tied high.
// Pipeline: an accepted event passes through the input register, then the state
//   update and result register; m_valid rises when the result register loads.
// Throughput: one event per cycle while m_ready does not hold the result; the
//   event state and LED shadows update with the result register, so events chain.
// Reset (synchronous, aresetn low): both pipeline stages empty, config back
//   to 180 / 1000 / 429, pulses and failures cleared, LEDs enabled, shadows
//   invalid, request count zero.
// Stall: while m_ready is low the result is held; one more event is taken
//   into the input register, then s_ready drops until the result drains.
module activity_led_indicator #(
    parameter int ENDPOINT_COUNT = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // event input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [31:0] s_now_ms,
    input  logic        s_success,
    input  logic [2:0]  s_ep_id,
    input  logic        s_transport_ok,
    input  logic [9:0]  s_http_status,
    input  logic        s_left_bus_ok,
    input  logic        s_right_bus_ok,
    // result output
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_write_left,
    output logic [2:0]  m_left_color,
    output logic        m_write_right,
    output logic [2:0]  m_right_color,
    output logic        m_release_all,
    output logic [7:0]  m_requests_open,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [15:0] pulse_ms_reg;
    logic [15:0] refresh_ms_reg;
    logic [9:0]  rate_limit_reg;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_ms_reg   <= ali_pkg::PULSE_MS_RST;
            refresh_ms_reg <= ali_pkg::REFRESH_MS_RST;
            rate_limit_reg <= ali_pkg::RATE_LIMIT_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                ali_pkg::REG_PULSE_MS:   pulse_ms_reg   <= pwdata[15:0];
                ali_pkg::REG_REFRESH_MS: refresh_ms_reg <= pwdata[15:0];
                ali_pkg::REG_RATE_LIMIT: rate_limit_reg <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            ali_pkg::REG_PULSE_MS:   prdata = {16'd0, pulse_ms_reg};
            ali_pkg::REG_REFRESH_MS: prdata = {16'd0, refresh_ms_reg};
            ali_pkg::REG_RATE_LIMIT: prdata = {22'd0, rate_limit_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------
    // Pipeline handshake: input register -> result register
    // ---------------------------------------------------------------
    logic in_v_reg;
    logic out_v_reg;
    logic out_free;
    logic proc;

    assign out_free = !out_v_reg || m_ready;
    assign proc     = in_v_reg && out_free;
    assign s_ready  = !in_v_reg || out_free;
    assign m_valid  = out_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_v_reg <= s_valid;
            end
            if (out_free) begin
                out_v_reg <= in_v_reg;
            end
        end
    end

    // Input register (payload only)
    logic [2:0]  func_reg;
    logic [31:0] now_reg;
    logic        success_reg;
    logic [2:0]  endpoint_reg;
    logic        transport_ok_reg;
    logic [9:0]  status_reg;
    logic        left_ok_reg;
    logic        right_ok_reg;

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg         <= s_func;
            now_reg          <= s_now_ms;
            success_reg      <= s_success;
            endpoint_reg     <= s_ep_id;
            transport_ok_reg <= s_transport_ok;
            status_reg       <= s_http_status;
            left_ok_reg      <= s_left_bus_ok;
            right_ok_reg     <= s_right_bus_ok;
        end
    end

    // ---------------------------------------------------------------
    // Event state
    // ---------------------------------------------------------------
    logic [31:0]      cam_stamp_reg,   cam_stamp_next;
    logic             cam_failed_reg,  cam_failed_next;
    logic [31:0]      net_stamp_reg,   net_stamp_next;
    logic             net_ok_reg,      net_ok_next;
    logic [9:0]       net_status_reg,  net_status_next;
    logic [7:0]       open_count_reg,  open_count_next;
    logic             enabled_reg,     enabled_next;
    logic             were_en_reg,     were_en_next;
    ali_pkg::color_t  shd_col_reg [2];
    ali_pkg::color_t  shd_col_next [2];
    logic [31:0]      shd_time_reg [2];
    logic [31:0]      shd_time_next [2];
    logic [1:0]       shd_valid_reg, shd_valid_next;

    // Per-event combinational values
    logic [31:0]      stamp_now;
    logic [31:0]      cam_age;
    logic [31:0]      net_age;
    logic             cam_lit;
    logic             net_lit;
    logic             ep_ok;
    ali_pkg::color_t  want [2];
    logic [1:0]       bus_ok;
    logic [1:0]       skip;
    logic [1:0]       wr_led;
    logic             rel;

    assign stamp_now = (now_reg == 32'd0) ? 32'd1 : now_reg;
    assign cam_age   = now_reg - cam_stamp_reg;
    assign net_age   = now_reg - net_stamp_reg;
    assign cam_lit   = (cam_stamp_reg != 32'd0) && (cam_age < {16'd0, pulse_ms_reg});
    assign net_lit   = (net_stamp_reg != 32'd0) && (net_age < {16'd0, pulse_ms_reg});
    assign ep_ok     = {1'b0, endpoint_reg} < 4'(ENDPOINT_COUNT);
    assign bus_ok    = {right_ok_reg, left_ok_reg};

    always_comb begin
        priority if (cam_failed_reg) begin
            want[0] = ali_pkg::COL_RED;
        end else if (cam_lit) begin
            want[0] = ali_pkg::COL_WHITE;
        end else begin
            want[0] = ali_pkg::COL_OFF;
        end

        priority if (open_count_reg != 8'd0) begin
            want[1] = ali_pkg::COL_BLUE;
        end else if (!net_ok_reg) begin
            want[1] = (net_status_reg == rate_limit_reg) ? ali_pkg::COL_YELLOW
                                                         : ali_pkg::COL_RED;
        end else if (net_lit) begin
            want[1] = ali_pkg::COL_GREEN;
        end else begin
            want[1] = ali_pkg::COL_OFF;
        end
    end

    // Shadow hit: same colour, still valid and younger than the refresh age.
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            skip[i] = shd_valid_reg[i] && (shd_col_reg[i] == want[i]) &&
                      ((now_reg - shd_time_reg[i]) < {16'd0, refresh_ms_reg});
        end
    end

    always_comb begin
        cam_stamp_next  = cam_stamp_reg;
        cam_failed_next = cam_failed_reg;
        net_stamp_next  = net_stamp_reg;
        net_ok_next     = net_ok_reg;
        net_status_next = net_status_reg;
        open_count_next = open_count_reg;
        enabled_next    = enabled_reg;
        were_en_next    = were_en_reg;
        shd_col_next    = shd_col_reg;
        shd_time_next   = shd_time_reg;
        shd_valid_next  = shd_valid_reg;
        wr_led          = 2'b00;
        rel             = 1'b0;

        unique case (func_reg)
            ali_pkg::FUNC_TICK: begin
                if (!enabled_reg) begin
                    if (were_en_reg) begin
                        rel            = 1'b1;
                        shd_valid_next = 2'b00;
                        were_en_next   = 1'b0;
                    end
                end else begin
                    were_en_next = 1'b1;
                    for (int i = 0; i < 2; i++) begin
                        wr_led[i] = !skip[i];
                        if (!skip[i]) begin
                            shd_valid_next[i] = bus_ok[i];
                            if (bus_ok[i]) begin
                                shd_col_next[i]  = want[i];
                                shd_time_next[i] = now_reg;
                            end
                        end
                    end
                end
            end
            ali_pkg::FUNC_CAMERA: begin
                cam_failed_next = !success_reg;
                if (success_reg) begin
                    cam_stamp_next = stamp_now;
                end
            end
            ali_pkg::FUNC_REQ_BEGIN: begin
                if (ep_ok && (open_count_reg != ali_pkg::OPEN_MAX)) begin
                    open_count_next = open_count_reg + 8'd1;
                end
            end
            ali_pkg::FUNC_REQ_END: begin
                if (ep_ok) begin
                    if (open_count_reg != 8'd0) begin
                        open_count_next = open_count_reg - 8'd1;
                    end
                    net_ok_next     = transport_ok_reg && (status_reg == ali_pkg::HTTP_OK);
                    net_status_next = status_reg;
                    net_stamp_next  = stamp_now;
                end
            end
            ali_pkg::FUNC_RESET: begin
                cam_failed_next = 1'b0;
                cam_stamp_next  = 32'd0;
                net_ok_next     = 1'b1;
                net_status_next = 10'd0;
                net_stamp_next  = 32'd0;
            end
            ali_pkg::FUNC_ENABLE: begin
                enabled_next = success_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_stamp_reg  <= 32'd0;
            cam_failed_reg <= 1'b0;
            net_stamp_reg  <= 32'd0;
            net_ok_reg     <= 1'b1;
            net_status_reg <= 10'd0;
            open_count_reg <= 8'd0;
            enabled_reg    <= 1'b1;
            were_en_reg    <= 1'b1;
            shd_valid_reg  <= 2'b00;
            for (int i = 0; i < 2; i++) begin
                shd_col_reg[i]  <= ali_pkg::COL_OFF;
                shd_time_reg[i] <= 32'd0;
            end
        end else if (proc) begin
            cam_stamp_reg  <= cam_stamp_next;
            cam_failed_reg <= cam_failed_next;
            net_stamp_reg  <= net_stamp_next;
            net_ok_reg     <= net_ok_next;
            net_status_reg <= net_status_next;
            open_count_reg <= open_count_next;
            enabled_reg    <= enabled_next;
            were_en_reg    <= were_en_next;
            shd_valid_reg  <= shd_valid_next;
            shd_col_reg    <= shd_col_next;
            shd_time_reg   <= shd_time_next;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic       wl_reg, wr_reg, rel_reg;
    logic [2:0] lc_reg, rc_reg;
    logic [7:0] open_out_reg;

    always_ff @(posedge aclk) begin
        if (proc) begin
            wl_reg       <= wr_led[0];
            lc_reg       <= wr_led[0] ? want[0] : ali_pkg::COL_OFF;
            wr_reg       <= wr_led[1];
            rc_reg       <= wr_led[1] ? want[1] : ali_pkg::COL_OFF;
            rel_reg      <= rel;
            open_out_reg <= open_count_next;
        end
    end

    assign m_write_left    = wl_reg;
    assign m_left_color    = lc_reg;
    assign m_write_right   = wr_reg;
    assign m_right_color   = rc_reg;
    assign m_release_all   = rel_reg;
    assign m_requests_open = open_out_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_release_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_release_all && (m_write_left || m_write_right)))
        else $error("release_all together with an LED write");

    a_color_gated: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_write_left) |-> (m_left_color == ali_pkg::COL_OFF))
        else $error("left colour set without a write");

    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$past(proc)) |-> $stable(open_count_reg))
        else $error("open count moved without an event");

    a_release_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && rel) |=> (!were_en_reg && (shd_valid_reg == 2'b00)))
        else $error("release did not clear shadows");

    a_count_out: assert property (@(posedge aclk) disable iff (!aresetn)
        proc |=> (m_requests_open == open_count_reg))
        else $error("requests_open differs from state");

endmodule
